[sv/gbpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the B-panel pack address generator.
// No dependencies; imported by every module of the block.
package gbpa_pkg;

   localparam int IDX_W      = 28;   // packed_index
   localparam int NC_W       = 16;   // num_cols, n_index
   localparam int DEPTH_W    = 13;
   localparam int PW_W       = 8;    // panel_width, chunk_width
   localparam int STRIDE_W   = 24;
   localparam int K_W        = 12;
   localparam int ADDR_W     = 40;
   localparam int LEN_W      = IDX_W + 1;
   localparam int MAX_PANEL  = 128;
   localparam int KC_MAX     = 4096;
   localparam int WIDE_CHUNK = 32;   // narrowest first chunk, also the padded tail width

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_STRIDE  = 3'd4;

   localparam logic [PW_W-1:0] CHUNK_96 = 8'd96;
   localparam logic [PW_W-1:0] CHUNK_64 = 8'd64;
   localparam logic [PW_W-1:0] CHUNK_32 = 8'd32;

   typedef enum logic [1:0] {
      REG_FULL = 2'd0,
      REG_C1   = 2'd1,
      REG_C2   = 2'd2,
      REG_OOR  = 2'd3
   } region_type;

   // derived layout, held steady while items flow
   typedef struct packed {
      logic [PW_W-1:0]     nr;
      logic [DEPTH_W-1:0]  kc;
      logic [NC_W-1:0]     base;
      logic [PW_W-1:0]     c1;
      logic [PW_W-1:0]     r2;
      logic [PW_W-1:0]     w2;
      logic [LEN_W-1:0]    full_len;
      logic [LEN_W-1:0]    end1;
      logic [LEN_W-1:0]    end2;
      logic [STRIDE_W-1:0] row_stride;
      logic [STRIDE_W-1:0] col_stride;
   } cfg_type;

   typedef struct packed {
      region_type       region;
      logic [IDX_W-1:0] xr;
      logic [PW_W-1:0]  w;
   } job_type;

   typedef struct packed {
      logic [K_W-1:0]    k_index;
      logic [NC_W-1:0]   n_index;
      logic              is_pad;
      logic              out_of_range;
      logic [PW_W-1:0]   chunk_width;
      logic [ADDR_W-1:0] source_addr;
   } rsp_type;

endpackage

[sv/gbpa_config.sv]
`timescale 1ns / 1ps
// Configuration registers and the sequencer that derives the panel layout.
// Depends on gbpa_pkg.
module gbpa_config (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gbpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbpa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output gbpa_pkg::cfg_type                  cfg,
   output logic                               busy
);
   import gbpa_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_END1 = 6'b010000,
      ST_END2 = 6'b100000
   } cfg_state_type;

   localparam int CNT_W = $clog2(NC_W);

   logic [NC_W-1:0]     num_cols_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [PW_W-1:0]     panel_ff;
   logic [STRIDE_W-1:0] row_ff;
   logic [STRIDE_W-1:0] col_ff;

   cfg_state_type       state_ff, state_in;
   logic [PW_W-1:0]     nr_ff, nr_in;
   logic [DEPTH_W-1:0]  kc_ff, kc_in;
   logic [PW_W-1:0]     rem_ff, rem_in;
   logic [NC_W-1:0]     dv_ff, dv_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NC_W-1:0]     base_ff, base_in;
   logic [PW_W-1:0]     c1_ff, c1_in;
   logic [PW_W-1:0]     r2_ff, r2_in;
   logic [PW_W-1:0]     w2_ff, w2_in;
   logic [LEN_W-1:0]    full_len_ff, full_len_in;
   logic [LEN_W-1:0]    c1kc_ff, c1kc_in;
   logic [LEN_W-1:0]    w2kc_ff, w2kc_in;
   logic [LEN_W-1:0]    end1_ff, end1_in;
   logic [LEN_W-1:0]    end2_ff, end2_in;

   logic [PW_W-1:0]     t;
   logic                ge;
   logic                wide;
   logic [LEN_W-1:0]    kc_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= 16'd1;
         depth_ff    <= 13'd1;
         panel_ff    <= 8'd64;
         row_ff      <= 24'd1;
         col_ff      <= 24'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_COLS:    num_cols_ff <= csr_wdata[NC_W-1:0];
            CSR_DEPTH:       depth_ff    <= csr_wdata[DEPTH_W-1:0];
            CSR_PANEL_WIDTH: panel_ff    <= csr_wdata[PW_W-1:0];
            CSR_ROW_STRIDE:  row_ff      <= csr_wdata[STRIDE_W-1:0];
            CSR_COL_STRIDE:  col_ff      <= csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      nr_in       = nr_ff;
      kc_in       = kc_ff;
      rem_in      = rem_ff;
      dv_in       = dv_ff;
      cnt_in      = cnt_ff;
      base_in     = base_ff;
      c1_in       = c1_ff;
      r2_in       = r2_ff;
      w2_in       = w2_ff;
      full_len_in = full_len_ff;
      c1kc_in     = c1kc_ff;
      w2kc_in     = w2kc_ff;
      end1_in     = end1_ff;
      end2_in     = end2_ff;
      t           = {rem_ff[PW_W-2:0], dv_ff[NC_W-1]};
      ge          = (t >= nr_ff);
      wide        = (nr_ff >= CHUNK_32);
      kc_ext      = {{(LEN_W-DEPTH_W){1'b0}}, kc_ff};

      unique case (state_ff)
         ST_LOAD: begin
            if (panel_ff == '0) begin
               nr_in = 8'd1;
            end else if (panel_ff > PW_W'(MAX_PANEL)) begin
               nr_in = PW_W'(MAX_PANEL);
            end else begin
               nr_in = panel_ff;
            end
            kc_in    = (depth_ff > DEPTH_W'(KC_MAX)) ? DEPTH_W'(KC_MAX) : depth_ff;
            rem_in   = '0;
            dv_in    = num_cols_ff;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // num_cols / panel width, one quotient bit a cycle
            rem_in = ge ? (t - nr_ff) : t;
            dv_in  = {dv_ff[NC_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NC_W-1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            base_in = num_cols_ff - {{(NC_W-PW_W){1'b0}}, rem_ff};
            if (wide && rem_ff >= CHUNK_96) begin
               c1_in = CHUNK_96;
            end else if (wide && rem_ff >= CHUNK_64) begin
               c1_in = CHUNK_64;
            end else if (wide && rem_ff >= CHUNK_32) begin
               c1_in = CHUNK_32;
            end else begin
               c1_in = '0;
            end
            r2_in = wide ? {3'b000, rem_ff[4:0]} : rem_ff;
            w2_in = wide ? PW_W'(WIDE_CHUNK) : nr_ff;
            full_len_in = {{(LEN_W-NC_W){1'b0}}, base_in} * kc_ext;
            if (c1_in == CHUNK_96) begin
               c1kc_in = (kc_ext << 6) + (kc_ext << 5);
            end else if (c1_in == CHUNK_64) begin
               c1kc_in = kc_ext << 6;
            end else if (c1_in == CHUNK_32) begin
               c1kc_in = kc_ext << 5;
            end else begin
               c1kc_in = '0;
            end
            w2kc_in  = {{(LEN_W-PW_W){1'b0}}, w2_in} * kc_ext;
            state_in = ST_END1;
         end
         ST_END1: begin
            end1_in  = full_len_ff + c1kc_ff;
            state_in = ST_END2;
         end
         ST_END2: begin
            end2_in  = (r2_ff != '0) ? (end1_ff + w2kc_ff) : end1_ff;
            state_in = ST_IDLE;
         end
         ST_IDLE: ;
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else if (csr_we) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
      nr_ff       <= nr_in;
      kc_ff       <= kc_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      cnt_ff      <= cnt_in;
      base_ff     <= base_in;
      c1_ff       <= c1_in;
      r2_ff       <= r2_in;
      w2_ff       <= w2_in;
      full_len_ff <= full_len_in;
      c1kc_ff     <= c1kc_in;
      w2kc_ff     <= w2kc_in;
      end1_ff     <= end1_in;
      end2_ff     <= end2_in;
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cfg.nr         = nr_ff;
      cfg.kc         = kc_ff;
      cfg.base       = base_ff;
      cfg.c1         = c1_ff;
      cfg.r2         = r2_ff;
      cfg.w2         = w2_ff;
      cfg.full_len   = full_len_ff;
      cfg.end1       = end1_ff;
      cfg.end2       = end2_ff;
      cfg.row_stride = row_ff;
      cfg.col_stride = col_ff;
   end

endmodule

[sv/gbpa_front.sv]
`timescale 1ns / 1ps
// Front end: takes packed positions, sorts them into full panel, first or
// second leftover chunk, or out of range, and queues the job. Depends on gbpa_pkg.
module gbpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          busy,
   input  gbpa_pkg::cfg_type             cfg,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [gbpa_pkg::IDX_W-1:0]    req_packed_index,
   input  logic                          q_pop,
   output logic                          q_empty,
   output gbpa_pkg::job_type             q_head
);
   import gbpa_pkg::*;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   job_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wp_ff, wp_in;
   logic [QPTR_W-1:0]  rp_ff, rp_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               push;
   logic [LEN_W-1:0]   x_ext;
   job_type            job;

   assign req_full = reset || busy || (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign push     = req_push && !req_full;
   assign q_empty  = (cnt_ff == '0);
   assign q_head   = mem_ff[rp_ff];
   assign x_ext    = {1'b0, req_packed_index};

   always_comb begin
      priority if (x_ext < cfg.full_len) begin
         job.region = REG_FULL;
         job.xr     = req_packed_index;
         job.w      = cfg.nr;
      end else if (x_ext < cfg.end1) begin
         job.region = REG_C1;
         job.xr     = req_packed_index - cfg.full_len[IDX_W-1:0];
         job.w      = cfg.c1;
      end else if (x_ext < cfg.end2) begin
         job.region = REG_C2;
         job.xr     = req_packed_index - cfg.end1[IDX_W-1:0];
         job.w      = cfg.w2;
      end else begin
         job.region = REG_OOR;
         job.xr     = req_packed_index;
         job.w      = cfg.nr;
      end
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = q_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= job;
      end
   end

endmodule

[sv/gbpa_back.sv]
`timescale 1ns / 1ps
// Back end: two pipelined restoring dividers (by chunk width, then by depth),
// column and address arithmetic, and a two-entry result queue. Depends on gbpa_pkg.
module gbpa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gbpa_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   input  gbpa_pkg::job_type             q_head,
   output logic                          q_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output gbpa_pkg::rsp_type             rsp
);
   import gbpa_pkg::*;

   localparam int N1     = IDX_W;
   localparam int N2     = IDX_W;
   localparam int R2_W   = K_W;
   localparam int OQ_D   = 2;
   localparam int OQP_W  = $clog2(OQ_D);

   // divider one: position / chunk width
   logic               d1_v_ff   [N1];
   logic               d1_v_in   [N1];
   logic [PW_W-1:0]    d1_rem_ff [N1];
   logic [PW_W-1:0]    d1_rem_in [N1];
   logic [IDX_W-1:0]   d1_dv_ff  [N1];
   logic [IDX_W-1:0]   d1_dv_in  [N1];
   region_type         d1_reg_ff [N1];
   region_type         d1_reg_in [N1];
   logic [PW_W-1:0]    d1_w_ff   [N1];
   logic [PW_W-1:0]    d1_w_in   [N1];

   // divider two: row-of-chunks / depth
   logic               d2_v_ff   [N2];
   logic               d2_v_in   [N2];
   logic [R2_W-1:0]    d2_rem_ff [N2];
   logic [R2_W-1:0]    d2_rem_in [N2];
   logic [IDX_W-1:0]   d2_dv_ff  [N2];
   logic [IDX_W-1:0]   d2_dv_in  [N2];
   region_type         d2_reg_ff [N2];
   region_type         d2_reg_in [N2];
   logic [PW_W-1:0]    d2_w_ff   [N2];
   logic [PW_W-1:0]    d2_w_in   [N2];
   logic [PW_W-1:0]    d2_i_ff   [N2];
   logic [PW_W-1:0]    d2_i_in   [N2];

   logic               m_v_ff, m_v_in;
   logic [K_W-1:0]     m_k_ff, m_k_in;
   logic [NC_W-1:0]    m_n_ff, m_n_in;
   logic               m_pad_ff, m_pad_in;
   logic               m_oor_ff, m_oor_in;
   logic [PW_W-1:0]    m_cw_ff, m_cw_in;

   logic               a_v_ff;
   logic [K_W-1:0]     a_k_ff;
   logic [NC_W-1:0]    a_n_ff;
   logic               a_pad_ff;
   logic               a_oor_ff;
   logic [PW_W-1:0]    a_cw_ff;
   logic [K_W+STRIDE_W-1:0] a_kr_ff, a_kr_in;
   logic [ADDR_W-1:0]  a_nc_ff, a_nc_in;

   rsp_type            oq_ff [OQ_D];
   logic [OQP_W-1:0]   owp_ff, orp_ff;
   logic [OQP_W:0]     ocnt_ff, ocnt_in;

   logic               en;
   logic               opush;
   logic               opop;
   rsp_type            res;
   logic [ADDR_W:0]    sum;
   logic [PW_W-1:0]    t1;
   logic [R2_W:0]      t2;
   logic               ge1;
   logic               ge2;
   logic [PW_W-1:0]    s1_rem;
   logic [IDX_W-1:0]   s1_dv;
   logic [R2_W-1:0]    s2_rem;
   logic [IDX_W-1:0]   s2_dv;
   logic [NC_W+PW_W-1:0] n_full;
   logic [PW_W-1:0]    last_i;
   logic [PW_W-1:0]    last_w;
   region_type         last_reg;

   // whole pipeline moves together; it stops only when the result queue is full
   assign en    = (ocnt_ff != (OQP_W+1)'(OQ_D));
   assign q_pop = en && !q_empty;

   always_comb begin
      for (int s = 0; s < N1; s++) begin
         if (s == 0) begin
            d1_v_in[s]   = q_pop;
            s1_rem       = '0;
            s1_dv        = q_head.xr;
            d1_reg_in[s] = q_head.region;
            d1_w_in[s]   = q_head.w;
         end else begin
            d1_v_in[s]   = d1_v_ff[s-1];
            s1_rem       = d1_rem_ff[s-1];
            s1_dv        = d1_dv_ff[s-1];
            d1_reg_in[s] = d1_reg_ff[s-1];
            d1_w_in[s]   = d1_w_ff[s-1];
         end
         t1           = {s1_rem[PW_W-2:0], s1_dv[IDX_W-1]};
         ge1          = (t1 >= d1_w_in[s]);
         d1_rem_in[s] = ge1 ? (t1 - d1_w_in[s]) : t1;
         d1_dv_in[s]  = {s1_dv[IDX_W-2:0], ge1};
      end
   end

   always_comb begin
      for (int s = 0; s < N2; s++) begin
         if (s == 0) begin
            d2_v_in[s]   = d1_v_ff[N1-1];
            s2_rem       = '0;
            s2_dv        = d1_dv_ff[N1-1];
            d2_reg_in[s] = d1_reg_ff[N1-1];
            d2_w_in[s]   = d1_w_ff[N1-1];
            d2_i_in[s]   = d1_rem_ff[N1-1];
         end else begin
            d2_v_in[s]   = d2_v_ff[s-1];
            s2_rem       = d2_rem_ff[s-1];
            s2_dv        = d2_dv_ff[s-1];
            d2_reg_in[s] = d2_reg_ff[s-1];
            d2_w_in[s]   = d2_w_ff[s-1];
            d2_i_in[s]   = d2_i_ff[s-1];
         end
         t2           = {s2_rem, s2_dv[IDX_W-1]};
         ge2          = (t2 >= {{(R2_W+1-DEPTH_W){1'b0}}, cfg.kc});
         t2           = ge2 ? (t2 - {{(R2_W+1-DEPTH_W){1'b0}}, cfg.kc}) : t2;
         d2_rem_in[s] = t2[R2_W-1:0];
         d2_dv_in[s]  = {s2_dv[IDX_W-2:0], ge2};
      end
   end

   // column, padding and chunk width
   always_comb begin
      last_i   = d2_i_ff[N2-1];
      last_w   = d2_w_ff[N2-1];
      last_reg = d2_reg_ff[N2-1];
      n_full   = {{PW_W{1'b0}}, d2_dv_ff[N2-1][NC_W-1:0]} * {{NC_W{1'b0}}, cfg.nr}
               + {{NC_W{1'b0}}, last_i};
      m_v_in   = d2_v_ff[N2-1];
      m_k_in   = d2_rem_ff[N2-1];
      m_cw_in  = last_w;
      m_pad_in = 1'b0;
      m_oor_in = 1'b0;
      unique case (last_reg)
         REG_FULL: m_n_in = n_full[NC_W-1:0];
         REG_C1:   m_n_in = cfg.base + {{(NC_W-PW_W){1'b0}}, last_i};
         REG_C2: begin
            m_n_in   = cfg.base + {{(NC_W-PW_W){1'b0}}, cfg.c1}
                     + {{(NC_W-PW_W){1'b0}}, last_i};
            m_pad_in = (last_i >= cfg.r2);
         end
         default: begin
            m_n_in   = '0;
            m_k_in   = '0;
            m_cw_in  = '0;
            m_pad_in = 1'b1;
            m_oor_in = 1'b1;
         end
      endcase
      if (m_pad_in) begin
         m_n_in = '0;
      end
   end

   always_comb begin
      a_kr_in = {{STRIDE_W{1'b0}}, m_k_ff} * {{K_W{1'b0}}, cfg.row_stride};
      a_nc_in = {{(ADDR_W-NC_W){1'b0}}, m_n_ff} * {{(ADDR_W-STRIDE_W){1'b0}}, cfg.col_stride};
   end

   always_comb begin
      sum = {{(ADDR_W+1-K_W-STRIDE_W){1'b0}}, a_kr_ff} + {1'b0, a_nc_ff};
      res.k_index      = a_k_ff;
      res.n_index      = a_n_ff;
      res.is_pad       = a_pad_ff;
      res.out_of_range = a_oor_ff;
      res.chunk_width  = a_cw_ff;
      if (a_pad_ff) begin
         res.source_addr = '0;
      end else if (sum[ADDR_W]) begin
         res.source_addr = '1;
      end else begin
         res.source_addr = sum[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < N1; s++) begin
            d1_v_ff[s] <= 1'b0;
         end
         for (int s = 0; s < N2; s++) begin
            d2_v_ff[s] <= 1'b0;
         end
         m_v_ff <= 1'b0;
         a_v_ff <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < N1; s++) begin
            d1_v_ff[s] <= d1_v_in[s];
         end
         for (int s = 0; s < N2; s++) begin
            d2_v_ff[s] <= d2_v_in[s];
         end
         m_v_ff <= m_v_in;
         a_v_ff <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < N1; s++) begin
            d1_rem_ff[s] <= d1_rem_in[s];
            d1_dv_ff[s]  <= d1_dv_in[s];
            d1_reg_ff[s] <= d1_reg_in[s];
            d1_w_ff[s]   <= d1_w_in[s];
         end
         for (int s = 0; s < N2; s++) begin
            d2_rem_ff[s] <= d2_rem_in[s];
            d2_dv_ff[s]  <= d2_dv_in[s];
            d2_reg_ff[s] <= d2_reg_in[s];
            d2_w_ff[s]   <= d2_w_in[s];
            d2_i_ff[s]   <= d2_i_in[s];
         end
         m_k_ff   <= m_k_in;
         m_n_ff   <= m_n_in;
         m_pad_ff <= m_pad_in;
         m_oor_ff <= m_oor_in;
         m_cw_ff  <= m_cw_in;
         a_k_ff   <= m_k_ff;
         a_n_ff   <= m_n_ff;
         a_pad_ff <= m_pad_ff;
         a_oor_ff <= m_oor_ff;
         a_cw_ff  <= m_cw_ff;
         a_kr_ff  <= a_kr_in;
         a_nc_ff  <= a_nc_in;
      end
   end

   // result queue
   assign opush     = en && a_v_ff;
   assign rsp_empty = (ocnt_ff == '0);
   assign opop      = rsp_pop && !rsp_empty;
   assign rsp       = oq_ff[orp_ff];
   assign ocnt_in   = ocnt_ff + {{OQP_W{1'b0}}, opush} - {{OQP_W{1'b0}}, opop};

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (opush) begin
            owp_ff <= owp_ff + 1'b1;
         end
         if (opop) begin
            orp_ff <= orp_ff + 1'b1;
         end
         ocnt_ff <= ocnt_in;
      end
      if (opush) begin
         oq_ff[owp_ff] <= res;
      end
   end

endmodule

[sv/gemm_b_panel_pack_address_top.sv]
`timescale 1ns / 1ps
// Each accepted item runs through the two 28-stage divider pipelines to the rsp_
// ports. Throughput: one item per cycle while the result queue is not full.
// Reset and every csr_ write restart the layout sequencer: req_full is high
// while the divide by panel width and the chunk bounds are worked out.
// Reset is synchronous; configuration returns to its documented reset values.
module gemm_b_panel_pack_address_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [gbpa_pkg::IDX_W-1:0]        req_packed_index,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [gbpa_pkg::K_W-1:0]          rsp_k_index,
   output logic [gbpa_pkg::NC_W-1:0]         rsp_n_index,
   output logic                              rsp_is_pad,
   output logic                              rsp_out_of_range,
   output logic [gbpa_pkg::PW_W-1:0]         rsp_chunk_width,
   output logic [gbpa_pkg::ADDR_W-1:0]       rsp_source_addr,
   input  logic                              csr_we,
   input  logic [gbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gbpa_pkg::*;

   cfg_type cfg;
   logic    busy;
   logic    q_pop;
   logic    q_empty;
   job_type q_head;
   rsp_type rsp;

   gbpa_config u_config (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .busy      (busy)
   );

   gbpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .busy             (busy),
      .cfg              (cfg),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_packed_index (req_packed_index),
      .q_pop            (q_pop),
      .q_empty          (q_empty),
      .q_head           (q_head)
   );

   gbpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_k_index      = rsp.k_index;
   assign rsp_n_index      = rsp.n_index;
   assign rsp_is_pad       = rsp.is_pad;
   assign rsp_out_of_range = rsp.out_of_range;
   assign rsp_chunk_width  = rsp.chunk_width;
   assign rsp_source_addr  = rsp.source_addr;

endmodule

[sv/gbpa_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the pack address generator, bound to the top level.
// Depends on gbpa_pkg.
module gbpa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_full,
   input  logic                          csr_we,
   input  logic                          rsp_empty,
   input  logic                          rsp_pop,
   input  logic [gbpa_pkg::K_W-1:0]      rsp_k_index,
   input  logic [gbpa_pkg::NC_W-1:0]     rsp_n_index,
   input  logic                          rsp_is_pad,
   input  logic                          rsp_out_of_range,
   input  logic [gbpa_pkg::PW_W-1:0]     rsp_chunk_width,
   input  logic [gbpa_pkg::ADDR_W-1:0]   rsp_source_addr
);
   import gbpa_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_csr_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_full)
      else $error("item accepted while layout is being recomputed");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_source_addr) && $stable(rsp_k_index)))
      else $error("waiting item changed or vanished");

   a_oor_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_out_of_range) |->
         (rsp_is_pad && rsp_chunk_width == '0 && rsp_k_index == '0
          && rsp_source_addr == '0))
      else $error("out-of-range item carries data");

   a_pad_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_pad) |-> (rsp_n_index == '0 && rsp_source_addr == '0))
      else $error("padding item carries a column or address");

endmodule

bind gemm_b_panel_pack_address_top gbpa_checker u_gbpa_checker (.*);

[verif/gemm_b_panel_pack_address_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for gemm_b_panel_pack_address_top: predicts each lookup
// from a shadow copy of the layout registers. Depends on gbpa_pkg and the top.
module gemm_b_panel_pack_address_top_test;
   import gbpa_pkg::*;

   localparam int LATENCY = 59;
   localparam int SETTLE  = LATENCY + 30;

   logic                  clock;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [IDX_W-1:0]      req_packed_index;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [K_W-1:0]        rsp_k_index;
   logic [NC_W-1:0]       rsp_n_index;
   logic                  rsp_is_pad;
   logic                  rsp_out_of_range;
   logic [PW_W-1:0]       rsp_chunk_width;
   logic [ADDR_W-1:0]     rsp_source_addr;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gemm_b_panel_pack_address_top dut (.*);

   // shadow layout registers
   logic [NC_W-1:0]     sh_num_cols;
   logic [DEPTH_W-1:0]  sh_depth;
   logic [PW_W-1:0]     sh_panel_width;
   logic [STRIDE_W-1:0] sh_row_stride;
   logic [STRIDE_W-1:0] sh_col_stride;

   logic [IDX_W-1:0] pending_indices[$];
   rsp_type          expected_lookups[$];
   int               mismatches;

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   function automatic longint unsigned clamped_panel();
      longint unsigned nr;
      nr = sh_panel_width;
      if (nr == 0) nr = 1;
      if (nr > MAX_PANEL) nr = MAX_PANEL;
      return nr;
   endfunction

   function automatic longint unsigned clamped_depth();
      return (sh_depth > KC_MAX) ? KC_MAX : sh_depth;
   endfunction

   // whole packed length for the current layout, used to aim the stimulus
   function automatic longint unsigned packed_length();
      longint unsigned nr, kc, left, c1, len;
      nr = clamped_panel();
      kc = clamped_depth();
      left = sh_num_cols % nr;
      c1 = 0;
      len = (sh_num_cols / nr) * nr * kc;
      if (nr >= WIDE_CHUNK) begin
         if (left >= 96) c1 = 96;
         else if (left >= 64) c1 = 64;
         else if (left >= 32) c1 = 32;
         len += c1 * kc;
         if (left % WIDE_CHUNK != 0) len += WIDE_CHUNK * kc;
      end else if (left != 0) begin
         len += nr * kc;
      end
      return len;
   endfunction

   function automatic rsp_type lookup_element(logic [IDX_W-1:0] idx);
      longint unsigned x, kc, nr, nfull, left, full_len, c1, w2, r2;
      longint unsigned k, n, cw, span, base, i, a, lim;
      bit pad, oor;
      rsp_type r;
      x = idx;
      kc = clamped_depth();
      nr = clamped_panel();
      nfull = sh_num_cols / nr;
      left = sh_num_cols % nr;
      full_len = nfull * nr * kc;
      c1 = 0; k = 0; n = 0; cw = 0;
      pad = 1'b1; oor = 1'b0;
      if (nr >= WIDE_CHUNK) begin
         if (left >= 96) c1 = 96;
         else if (left >= 64) c1 = 64;
         else if (left >= 32) c1 = 32;
         w2 = WIDE_CHUNK;
         r2 = left % WIDE_CHUNK;
      end else begin
         w2 = nr;
         r2 = left;
      end
      if (kc == 0) begin
         oor = 1'b1;
      end else if (x < full_len) begin
         span = nr * kc;
         k = (x % span) / nr;
         n = (x / span) * nr + (x % span) % nr;
         cw = nr;
         pad = 1'b0;
      end else begin
         base = nfull * nr;
         x -= full_len;
         if (c1 > 0 && x < c1 * kc) begin
            k = x / c1;
            n = base + x % c1;
            cw = c1;
            pad = 1'b0;
         end else begin
            x -= c1 * kc;
            if (r2 > 0 && x < w2 * kc) begin
               i = x % w2;
               k = x / w2;
               cw = w2;
               if (i < r2) begin
                  n = base + c1 + i;
                  pad = 1'b0;
               end
            end else begin
               oor = 1'b1;
            end
         end
      end
      lim = (64'd1 << ADDR_W) - 1;
      a = k * sh_row_stride + n * sh_col_stride;
      if (a > lim) a = lim;
      r.k_index      = K_W'(k);
      r.n_index      = pad ? '0 : NC_W'(n);
      r.is_pad       = pad;
      r.out_of_range = oor;
      r.chunk_width  = PW_W'(cw);
      r.source_addr  = pad ? '0 : ADDR_W'(a);
      return r;
   endfunction

   // sender: bursts of items with random gaps, held while full is high
   always @(posedge clock) begin : sender
      int burst_left;
      int gap_left;
      int avail;
      if (reset) begin
         req_push <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         avail = pending_indices.size();
         if (req_push && !req_full) begin
            expected_lookups.push_back(lookup_element(req_packed_index));
            void'(pending_indices.pop_front());
            avail--;
         end
         if (!(req_push && req_full)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (avail > 0) begin
               req_push <= 1'b1;
               req_packed_index <= pending_indices[0];
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
               end
               burst_left--;
               if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver: alternates between stretches of free flow and random stalls
   always @(posedge clock) begin : receiver
      rsp_type got;
      rsp_type want;
      int unsigned tick;
      if (reset) begin
         rsp_pop <= 1'b0;
         tick = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_k_index, rsp_n_index, rsp_is_pad, rsp_out_of_range,
                   rsp_chunk_width, rsp_source_addr};
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
               want = expected_lookups.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
         tick++;
         case (tick[9:8])
            2'd0:    rsp_pop <= 1'b1;
            2'd1:    rsp_pop <= ($urandom_range(0, 3) != 0);
            2'd2:    rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= tick[2];
         endcase
      end
   end

   task automatic wait_drained();
      wait (pending_indices.size() == 0 && expected_lookups.size() == 0 && !req_push);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_NUM_COLS:    sh_num_cols = val[NC_W-1:0];
         CSR_DEPTH:       sh_depth = val[DEPTH_W-1:0];
         CSR_PANEL_WIDTH: sh_panel_width = val[PW_W-1:0];
         CSR_ROW_STRIDE:  sh_row_stride = val;
         CSR_COL_STRIDE:  sh_col_stride = val;
         default: ;
      endcase
   endtask

   task automatic set_layout(int nc, int dp, int pw, int rs, int cs);
      wait_drained();
      write_reg(CSR_NUM_COLS, CSR_DATA_W'(nc));
      write_reg(CSR_DEPTH, CSR_DATA_W'(dp));
      write_reg(CSR_PANEL_WIDTH, CSR_DATA_W'(pw));
      write_reg(CSR_ROW_STRIDE, CSR_DATA_W'(rs));
      write_reg(CSR_COL_STRIDE, CSR_DATA_W'(cs));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // boundary positions, then mostly in-range random positions
   task automatic queue_items(int count);
      longint unsigned len, span;
      len = packed_length();
      span = len + len / 8 + 4;
      if (span > 64'hFFF_FFFF) span = 64'hFFF_FFFF;
      pending_indices.push_back('0);
      pending_indices.push_back(IDX_W'(len));
      pending_indices.push_back(IDX_W'(len - 1));
      pending_indices.push_back(IDX_W'(len + 1));
      pending_indices.push_back(IDX_W'(clamped_panel() * clamped_depth()));
      pending_indices.push_back('1);
      for (int j = 0; j < count; j++) begin
         if ($urandom_range(0, 9) == 0) pending_indices.push_back(IDX_W'($urandom));
         else pending_indices.push_back(IDX_W'($urandom_range(0, int'(span))));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_packed_index = '0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_NUM_COLS;
      csr_wdata = '0;
      mismatches = 0;
      sh_num_cols = 1;
      sh_depth = 1;
      sh_panel_width = 64;
      sh_row_stride = 1;
      sh_col_stride = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_items(40);
      set_layout(228, 5, 128, 1000, 1);           // 96-wide chunk plus padded tail
      queue_items(90);
      set_layout(50, 3, 20, 1, 300);              // narrow panels
      queue_items(90);
      set_layout(65535, 4096, 128, 24'hFFFFFF, 24'hFFFFFF);
      queue_items(90);
      set_layout(0, 7, 32, 5, 5);                 // no columns
      queue_items(30);
      set_layout(300, 0, 8, 2, 3);                // no rows
      queue_items(30);
      set_layout(1000, 8191, 0, 3, 7);            // depth and width clamps
      queue_items(90);
      set_layout(250, 9, 255, 0, 0);
      queue_items(90);
      for (int ph = 0; ph < 6; ph++) begin
         set_layout($urandom_range(1, 600), $urandom_range(1, 16), $urandom_range(1, 128),
                    $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
         queue_items(90);
      end

      wait_drained();
      if (mismatches == 0 && expected_lookups.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/gbpa_pkg.sv
sv/gbpa_config.sv
sv/gbpa_front.sv
sv/gbpa_back.sv
sv/gemm_b_panel_pack_address_top.sv
sv/gbpa_checker.sv
verif/gemm_b_panel_pack_address_top_test.sv
